// ===== src/npsf_pkg.sv =====
// shared constants, types and helper functions for the nearest point search block
`default_nettype none

package npsf_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 5;

    // field widths
    localparam int COORD_W = 25;
    localparam int KIND_W  = 4;
    localparam int RANGE_W = 25;
    localparam int ABS_W   = 25;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int DIST_W  = 52;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic start_query;
        logic write_entry;
        logic issue;
        logic load_result;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last_addr;
        logic pipe_busy;
    } sts_t;

    // magnitude of the difference of two signed coordinates
    function automatic logic [ABS_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = {b[COORD_W-1], b} - {a[COORD_W-1], a};
        if (d[COORD_W])
        begin
            abs_diff = n[ABS_W-1:0];
        end
        else
        begin
            abs_diff = d[ABS_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/npsf_ctrl.sv =====
// controller state machine: sequences writes, table scans and result hand-off
`default_nettype none

module npsf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           req_type,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire npsf_pkg::sts_t sts,
    output npsf_pkg::cmd_t      cmd
);
    import npsf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        in_ready         = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_QUERY)
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/npsf_dpath.sv =====
// datapath: entry table, distance pipeline, best-candidate tracking and result register
`default_nettype none

module npsf_dpath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire npsf_pkg::cmd_t                         cmd,
    output npsf_pkg::sts_t                              sts,
    input  wire logic [4:0]                             entry_index,
    input  wire logic signed [npsf_pkg::COORD_W-1:0]    pos_x,
    input  wire logic signed [npsf_pkg::COORD_W-1:0]    pos_y,
    input  wire logic signed [npsf_pkg::COORD_W-1:0]    pos_z,
    input  wire logic                                   entry_enabled,
    input  wire logic [npsf_pkg::KIND_W-1:0]            kind_code,
    input  wire logic                                   filter_by_kind,
    input  wire logic [npsf_pkg::RANGE_W-1:0]           max_range_cm,
    output logic                                        found,
    output logic [npsf_pkg::IDX_W-1:0]                  best_index,
    output logic [npsf_pkg::DIST_W-1:0]                 best_dist_sq
);
    import npsf_pkg::*;

    // entry table
    logic signed [COORD_W-1:0] mem_x [TABLE_DEPTH];
    logic signed [COORD_W-1:0] mem_y [TABLE_DEPTH];
    logic signed [COORD_W-1:0] mem_z [TABLE_DEPTH];
    logic [KIND_W-1:0]         mem_kind [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    on_reg;

    // query parameters
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;
    logic signed [COORD_W-1:0] qz_reg;
    logic [KIND_W-1:0]         q_kind_reg;
    logic                      q_filt_reg;
    logic                      q_nolimit_reg;
    logic [SQ_W-1:0]           range_sq_reg;
    logic                      is_query_reg;

    // scan address
    logic [ADDR_W-1:0]         addr_reg;
    logic [ADDR_W-1:0]         waddr;
    logic                      wr_ok;

    // pipeline stage 1: table read
    logic                      v1_reg;
    logic signed [COORD_W-1:0] rd_x_reg;
    logic signed [COORD_W-1:0] rd_y_reg;
    logic signed [COORD_W-1:0] rd_z_reg;
    logic [KIND_W-1:0]         rd_kind_reg;
    logic                      rd_on_reg;
    logic [ADDR_W-1:0]         idx1_reg;

    // pipeline stage 2: differences
    logic                      v2_reg;
    logic                      ok2_reg;
    logic [ABS_W-1:0]          ad_x_reg;
    logic [ABS_W-1:0]          ad_y_reg;
    logic [ABS_W-1:0]          ad_z_reg;
    logic [ADDR_W-1:0]         idx2_reg;

    // pipeline stage 3: squares
    logic                      v3_reg;
    logic                      ok3_reg;
    logic [SQ_W-1:0]           sq_x_reg;
    logic [SQ_W-1:0]           sq_y_reg;
    logic [SQ_W-1:0]           sq_z_reg;
    logic [ADDR_W-1:0]         idx3_reg;

    // pipeline stage 4: sum
    logic                      v4_reg;
    logic                      ok4_reg;
    logic [DIST_W-1:0]         sum_reg;
    logic [ADDR_W-1:0]         idx4_reg;

    // best candidate
    logic                      have_reg;
    logic [ADDR_W-1:0]         best_idx_reg;
    logic [DIST_W-1:0]         best_d_reg;
    logic                      in_range;
    logic                      take;

    // result register
    logic                      found_reg;
    logic [IDX_W-1:0]          best_index_reg;
    logic [DIST_W-1:0]         best_dist_reg;

    assign wr_ok = cmd.write_entry && (32'(entry_index) < TABLE_DEPTH);
    assign waddr = ADDR_W'(entry_index);

    // table payload write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem_x[waddr]    <= pos_x;
            mem_y[waddr]    <= pos_y;
            mem_z[waddr]    <= pos_z;
            mem_kind[waddr] <= kind_code;
        end
        rd_x_reg    <= mem_x[addr_reg[ADDR_W-1:0]];
        rd_y_reg    <= mem_y[addr_reg[ADDR_W-1:0]];
        rd_z_reg    <= mem_z[addr_reg[ADDR_W-1:0]];
        rd_kind_reg <= mem_kind[addr_reg[ADDR_W-1:0]];
        rd_on_reg   <= on_reg[addr_reg[ADDR_W-1:0]];
        idx1_reg    <= addr_reg[ADDR_W-1:0];
    end

    // enable flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg <= '0;
        end
        else if (wr_ok)
        begin
            on_reg[waddr] <= entry_enabled;
        end
    end

    // query capture, range square computed on the request
    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            qx_reg        <= pos_x;
            qy_reg        <= pos_y;
            qz_reg        <= pos_z;
            q_kind_reg    <= kind_code;
            q_filt_reg    <= filter_by_kind;
            q_nolimit_reg <= (max_range_cm == '0);
            range_sq_reg  <= SQ_W'(max_range_cm) * SQ_W'(max_range_cm);
        end
    end

    // scan counter, pipeline valids and request kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            is_query_reg <= 1'b0;
            have_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.start_query)
            begin
                addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.start_query)
            begin
                is_query_reg <= 1'b1;
            end
            else if (cmd.write_entry)
            begin
                is_query_reg <= 1'b0;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.start_query)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    // distance pipeline payload
    always_ff @(posedge clk)
    begin
        ok2_reg  <= rd_on_reg && (!q_filt_reg || (rd_kind_reg == q_kind_reg));
        ad_x_reg <= abs_diff(rd_x_reg, qx_reg);
        ad_y_reg <= abs_diff(rd_y_reg, qy_reg);
        ad_z_reg <= abs_diff(rd_z_reg, qz_reg);
        idx2_reg <= idx1_reg;

        ok3_reg  <= ok2_reg;
        sq_x_reg <= SQ_W'(ad_x_reg) * SQ_W'(ad_x_reg);
        sq_y_reg <= SQ_W'(ad_y_reg) * SQ_W'(ad_y_reg);
        sq_z_reg <= SQ_W'(ad_z_reg) * SQ_W'(ad_z_reg);
        idx3_reg <= idx2_reg;

        ok4_reg  <= ok3_reg;
        sum_reg  <= DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
        idx4_reg <= idx3_reg;
    end

    // range test and nearest compare, strict less keeps the lower index on ties
    assign in_range = q_nolimit_reg || (sum_reg <= DIST_W'(range_sq_reg));
    assign take     = v4_reg && ok4_reg && in_range && (!have_reg || (sum_reg < best_d_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= idx4_reg;
            best_d_reg   <= sum_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            found_reg <= is_query_reg && have_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            if (is_query_reg && have_reg)
            begin
                best_index_reg <= IDX_W'(best_idx_reg);
                best_dist_reg  <= best_d_reg;
            end
            else
            begin
                best_index_reg <= '0;
                best_dist_reg  <= '0;
            end
        end
    end

    assign sts.last_addr = (addr_reg[ADDR_W-1:0] == ADDR_W'(TABLE_DEPTH - 1));
    assign sts.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    assign found        = found_reg;
    assign best_index   = best_index_reg;
    assign best_dist_sq = best_dist_reg;

endmodule

`default_nettype wire

// ===== src/nearest_point_search_filtered_top.sv =====
// top level of the nearest point search block: controller, datapath and checks
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid/in_ready, req_type .. max_range  | into block
//  result  | out_valid/out_ready, found, best_index,   | out of block
//          | best_dist_sq                              |
//
// A write request is accepted and then its result is loaded; a query runs the
// one-entry-per-cycle table scan, drains the read/difference/square/sum
// pipeline until it is seen empty, and then loads the result.
// Reset clears the enable flags and all control; positions and kinds are
// stored without reset. A stalled result blocks only the final result load;
// one request is in work at a time.
`default_nettype none

module nearest_point_search_filtered_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   req_type,
    input  wire logic [4:0]                             entry_index,
    input  wire logic signed [npsf_pkg::COORD_W-1:0]    pos_x,
    input  wire logic signed [npsf_pkg::COORD_W-1:0]    pos_y,
    input  wire logic signed [npsf_pkg::COORD_W-1:0]    pos_z,
    input  wire logic                                   entry_enabled,
    input  wire logic [npsf_pkg::KIND_W-1:0]            kind_code,
    input  wire logic                                   filter_by_kind,
    input  wire logic [npsf_pkg::RANGE_W-1:0]           max_range_cm,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        found,
    output logic [npsf_pkg::IDX_W-1:0]                  best_index,
    output logic [npsf_pkg::DIST_W-1:0]                 best_dist_sq
);
    import npsf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    npsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table and search datapath
    npsf_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .entry_index    (entry_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .entry_enabled  (entry_enabled),
        .kind_code      (kind_code),
        .filter_by_kind (filter_by_kind),
        .max_range_cm   (max_range_cm),
        .found          (found),
        .best_index     (best_index),
        .best_dist_sq   (best_dist_sq)
    );

`ifndef ASSERT_OFF
    // a new query never starts with entries still in the pipeline
    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_query |-> !sts.pipe_busy)
        else $error("query started with busy pipeline");

    // no request is taken while the table is being scanned
    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue || sts.pipe_busy) |-> !in_ready)
        else $error("request accepted during scan");

    // a result load always presents a result
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid)
        else $error("loaded result not presented");

    // a not-found result carries zero index and distance
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (best_index == '0 && best_dist_sq == '0))
        else $error("not-found result has nonzero payload");
`endif

endmodule

`default_nettype wire
